@@ rtl/bmsd_pkg.sv @@
// ---------------------------------------------------------------------------
// bmsd_pkg
// Shared types and constants for the kinematic bicycle model derivative:
// CORDIC arctangent table, datapath widths and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package bmsd_pkg;

  // cordic iteration count and datapath widths
  localparam int CORDIC_STEPS = 30;
  localparam int XW = 34;   // cordic x/y width, signed Q2.30 plus guard
  localparam int ZW = 33;   // residual phase width, signed
  localparam int QW = 31;   // tangent quotient bits

  // start vector with the cordic gain folded in
  localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;

  // tangent clip value, unsigned Q15.16
  localparam logic [QW-1:0] TAN_LIMIT = 31'h7FFF_FFFF;

  // arctangent of 2^-i as a 32-bit phase
  localparam logic [31:0] ATAN_PHASE [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODEL_ORDER   = 2'd0,
    CFG_INV_WHEELBASE = 2'd1
  } cfg_index_t;

endpackage

`default_nettype wire

@@ rtl/bmsd_cordic.sv @@
// ---------------------------------------------------------------------------
// bmsd_cordic
// Fully pipelined rotation-mode CORDIC: one micro-rotation per stage, then
// a quadrant fold. Gives cosine and sine of a 32-bit phase as signed Q2.30.
// ---------------------------------------------------------------------------
`default_nettype none

module bmsd_cordic import bmsd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [31:0]          phase,
  output logic signed [XW-1:0]      cos_val,
  output logic signed [XW-1:0]      sin_val
);

  logic signed [XW-1:0] xs [CORDIC_STEPS];
  logic signed [XW-1:0] ys [CORDIC_STEPS];
  logic signed [ZW-1:0] zs [CORDIC_STEPS];
  logic [1:0]           qs [CORDIC_STEPS];

  logic signed [XW-1:0] x_next [CORDIC_STEPS];
  logic signed [XW-1:0] y_next [CORDIC_STEPS];
  logic signed [ZW-1:0] z_next [CORDIC_STEPS];
  logic [1:0]           q_next [CORDIC_STEPS];

  // one micro-rotation per stage
  always_comb begin
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic signed [ZW-1:0] ai;
    logic [1:0]           qi;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        xi = CORDIC_X0;
        yi = '0;
        zi = $signed({3'b000, phase[29:0]});
        qi = phase[31:30];
      end else begin
        xi = xs[i-1];
        yi = ys[i-1];
        zi = zs[i-1];
        qi = qs[i-1];
      end
      ai = $signed({1'b0, ATAN_PHASE[i]});
      if (zi >= 0) begin
        x_next[i] = xi - (yi >>> i);
        y_next[i] = yi + (xi >>> i);
        z_next[i] = zi - ai;
      end else begin
        x_next[i] = xi + (yi >>> i);
        y_next[i] = yi - (xi >>> i);
        z_next[i] = zi + ai;
      end
      q_next[i] = qi;
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs[i] <= x_next[i];
        ys[i] <= y_next[i];
        zs[i] <= z_next[i];
        qs[i] <= q_next[i];
      end
    end
  end

  // quadrant fold
  always_ff @(posedge clk) begin
    if (en) begin
      case (qs[CORDIC_STEPS-1])
        2'd0: begin
          cos_val <= xs[CORDIC_STEPS-1];
          sin_val <= ys[CORDIC_STEPS-1];
        end
        2'd1: begin
          cos_val <= -ys[CORDIC_STEPS-1];
          sin_val <= xs[CORDIC_STEPS-1];
        end
        2'd2: begin
          cos_val <= -xs[CORDIC_STEPS-1];
          sin_val <= -ys[CORDIC_STEPS-1];
        end
        default: begin
          cos_val <= ys[CORDIC_STEPS-1];
          sin_val <= -xs[CORDIC_STEPS-1];
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/bicycle_model_state_derivative.sv @@
// ---------------------------------------------------------------------------
// bicycle_model_state_derivative
// Kinematic bicycle model state derivative, one result item per input item.
// ---------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled, and returns one
// result per item, in order. Two CORDIC pipelines of 30 stages plus a
// quadrant fold give the heading and steering sine/cosine, a 31-stage
// restoring divider forms tan(steer) in Q16.16, and two registered multiplies
// give the heading rate. The whole pipeline advances together: it holds only
// while the last stage carries an item that has not been taken. Configuration
// writes are always ready and are expected only while the pipeline is empty.
`default_nettype none

module bicycle_model_state_derivative import bmsd_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input items
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        heading,
  input  wire logic signed [15:0] speed,
  input  wire logic signed [14:0] steer_angle,
  input  wire logic signed [15:0] accel,
  input  wire logic signed [15:0] steer_rate_in,
  // result items
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      x_rate,
  output logic signed [15:0]      y_rate,
  output logic signed [31:0]      heading_rate,
  output logic signed [15:0]      speed_rate,
  output logic signed [15:0]      steer_rate_out,
  output logic                    saturated,
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int PH_SHIFT = 32 - ANGLE_BITS;
  localparam int ST_PROD  = CORDIC_STEPS + 1;
  localparam int ST_ROUND = CORDIC_STEPS + 2;
  localparam int ST_TAN   = ST_ROUND + QW + 1;
  localparam int ST_MUL   = ST_TAN + 1;
  localparam int ST_OUT   = ST_MUL + 1;
  localparam int LAT      = ST_OUT + 1;

  localparam logic signed [50:0] XY_RND = 51'sd536870912;
  localparam logic signed [50:0] XY_MAX = 51'sd32767;
  localparam logic signed [50:0] XY_MIN = -51'sd32768;
  localparam logic signed [64:0] HR_RND = 65'sd32768;
  localparam logic signed [64:0] HR_MAX = 65'sd2147483647;
  localparam logic signed [64:0] HR_MIN = -65'sd2147483648;

  // config registers
  logic        model_order;
  logic [15:0] inverse_wheelbase;

  // pipeline control
  logic           adv;
  logic [LAT-1:0] vld;

  // phases
  logic [31:0] phase_h;
  logic [31:0] phase_s;

  // cordic outputs
  logic signed [XW-1:0] hc, hs, sc, ss;

  // shift lines
  logic signed [15:0] speed_d [ST_PROD];
  logic signed [32:0] psi_d   [ST_TAN+1];
  logic signed [15:0] acc_d   [ST_OUT];
  logic signed [15:0] srt_d   [ST_OUT];
  logic signed [15:0] xr_d    [ST_OUT-ST_ROUND];
  logic signed [15:0] yr_d    [ST_OUT-ST_ROUND];

  // product stage
  logic signed [49:0] mx, my;
  logic [31:0]        ay_p, ax_p;
  logic               neg_p;

  // divider init stage
  logic [32:0] rem_r;
  logic [31:0] ay_r, ax_r;
  logic        ovf_r, neg_r;

  // divider stages
  logic [32:0]   drem [QW];
  logic [QW-1:0] dquo [QW];
  logic [31:0]   day  [QW];
  logic [31:0]   dax  [QW];
  logic          dovf [QW];
  logic          dneg [QW];
  logic [32:0]   drem_next [QW];
  logic [QW-1:0] dquo_next [QW];

  // tangent, multiply
  logic signed [31:0] tanv;
  logic               sat_t, sat_m;
  logic signed [64:0] big;

  // handshake
  assign adv       = !vld[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAT-1];
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      model_order       <= 1'b1;
      inverse_wheelbase <= 16'd512;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODEL_ORDER:   model_order       <= cfg_data[0];
        CFG_INV_WHEELBASE: inverse_wheelbase <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits travel with the item
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // binary angles to 32-bit phase
  assign phase_h = {16'b0, heading} << PH_SHIFT;
  assign phase_s = {{17{steer_angle[14]}}, steer_angle} << PH_SHIFT;

  bmsd_cordic u_cordic_h (
    .clk     (clk),
    .en      (adv),
    .phase   (phase_h),
    .cos_val (hc),
    .sin_val (hs)
  );

  bmsd_cordic u_cordic_s (
    .clk     (clk),
    .en      (adv),
    .phase   (phase_s),
    .cos_val (sc),
    .sin_val (ss)
  );

  // side fields and speed times inverse wheelbase
  always_ff @(posedge clk) begin
    if (adv) begin
      speed_d[0] <= speed;
      psi_d[0]   <= speed * $signed({1'b0, inverse_wheelbase});
      acc_d[0]   <= accel;
      srt_d[0]   <= steer_rate_in;
      for (int k = 1; k < ST_PROD; k++) speed_d[k] <= speed_d[k-1];
      for (int k = 1; k <= ST_TAN; k++) psi_d[k] <= psi_d[k-1];
      for (int k = 1; k < ST_OUT; k++) begin
        acc_d[k] <= acc_d[k-1];
        srt_d[k] <= srt_d[k-1];
      end
    end
  end

  // position rate products, tangent magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      mx    <= speed_d[ST_PROD-1] * hc;
      my    <= speed_d[ST_PROD-1] * hs;
      ay_p  <= ss[XW-1] ? 32'(-ss) : 32'(ss);
      ax_p  <= sc[XW-1] ? 32'(-sc) : 32'(sc);
      neg_p <= ss[XW-1] ^ sc[XW-1];
    end
  end

  // position rate rounding and clip, divider setup
  always_ff @(posedge clk) begin
    logic signed [50:0] sx, sy;
    sx = ($signed({mx[49], mx}) + XY_RND) >>> 30;
    sy = ($signed({my[49], my}) + XY_RND) >>> 30;
    if (adv) begin
      if (sx > XY_MAX)      xr_d[0] <= 16'sh7FFF;
      else if (sx < XY_MIN) xr_d[0] <= -16'sh8000;
      else                  xr_d[0] <= sx[15:0];
      if (sy > XY_MAX)      yr_d[0] <= 16'sh7FFF;
      else if (sy < XY_MIN) yr_d[0] <= -16'sh8000;
      else                  yr_d[0] <= sy[15:0];
      for (int k = 1; k < ST_OUT - ST_ROUND; k++) begin
        xr_d[k] <= xr_d[k-1];
        yr_d[k] <= yr_d[k-1];
      end
      rem_r <= {16'b0, ay_p[31:15]};
      ovf_r <= {15'b0, ay_p[31:15]} >= ax_p;
      ay_r  <= ay_p;
      ax_r  <= ax_p;
      neg_r <= neg_p;
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [32:0]   r_src;
    logic [QW-1:0] q_src;
    logic [31:0]   a_src;
    logic [31:0]   d_src;
    logic [32:0]   r2;
    logic          nbit;
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        r_src = rem_r;
        q_src = '0;
        a_src = ay_r;
        d_src = ax_r;
      end else begin
        r_src = drem[j-1];
        q_src = dquo[j-1];
        a_src = day[j-1];
        d_src = dax[j-1];
      end
      // dividend is |sin| << 16, bits below 16 are zero
      if (QW - 1 - j >= 16) nbit = a_src[5'(QW - 17 - j)];
      else                  nbit = 1'b0;
      r2 = {r_src[31:0], nbit};
      if (r2 >= {1'b0, d_src}) begin
        drem_next[j] = r2 - {1'b0, d_src};
        dquo_next[j] = {q_src[QW-2:0], 1'b1};
      end else begin
        drem_next[j] = r2;
        dquo_next[j] = {q_src[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < QW; j++) begin
        drem[j] <= drem_next[j];
        dquo[j] <= dquo_next[j];
      end
      day[0]  <= ay_r;
      dax[0]  <= ax_r;
      dovf[0] <= ovf_r;
      dneg[0] <= neg_r;
      for (int j = 1; j < QW; j++) begin
        day[j]  <= day[j-1];
        dax[j]  <= dax[j-1];
        dovf[j] <= dovf[j-1];
        dneg[j] <= dneg[j-1];
      end
    end
  end

  // tangent clip and sign
  always_ff @(posedge clk) begin
    logic          st;
    logic [QW-1:0] t;
    st = dovf[QW-1] || (dquo[QW-1] == TAN_LIMIT && drem[QW-1] != '0);
    t  = st ? TAN_LIMIT : dquo[QW-1];
    if (adv) begin
      sat_t <= st;
      tanv  <= dneg[QW-1] ? -$signed({1'b0, t}) : $signed({1'b0, t});
    end
  end

  // heading rate product
  always_ff @(posedge clk) begin
    if (adv) begin
      big   <= psi_d[ST_TAN] * tanv;
      sat_m <= sat_t;
    end
  end

  // heading rate rounding and clip, result registers
  always_ff @(posedge clk) begin
    logic signed [64:0] sh;
    sh = (big + HR_RND) >>> 16;
    if (adv) begin
      x_rate <= xr_d[ST_OUT-ST_ROUND-1];
      y_rate <= yr_d[ST_OUT-ST_ROUND-1];
      if (sh > HR_MAX) begin
        heading_rate <= 32'sh7FFF_FFFF;
        saturated    <= 1'b1;
      end else if (sh < HR_MIN) begin
        heading_rate <= -32'sh8000_0000;
        saturated    <= 1'b1;
      end else begin
        heading_rate <= sh[31:0];
        saturated    <= sat_m;
      end
      speed_rate     <= model_order ? acc_d[ST_OUT-1] : 16'sd0;
      steer_rate_out <= model_order ? srt_d[ST_OUT-1] : 16'sd0;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/bmsd_checker.sv @@
// ---------------------------------------------------------------------------
// bmsd_checker
// Watches the item, result and register write channels of the bicycle model
// derivative block, predicts each result from the accepted item and compares.
// ---------------------------------------------------------------------------
`default_nettype none

module bmsd_checker import bmsd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [15:0]        heading,
  input  wire logic signed [15:0] speed,
  input  wire logic signed [14:0] steer_angle,
  input  wire logic signed [15:0] accel,
  input  wire logic signed [15:0] steer_rate_in,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [15:0] x_rate,
  input  wire logic signed [15:0] y_rate,
  input  wire logic signed [31:0] heading_rate,
  input  wire logic signed [15:0] speed_rate,
  input  wire logic signed [15:0] steer_rate_out,
  input  wire logic               saturated,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output int                      fails,
  output int                      pending
);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [31:0] hr;
    logic signed [15:0] sr;
    logic signed [15:0] st;
    logic               sat;
  } deriv_t;

  localparam longint TAN_CLIP = 64'sd2147483647;

  logic        second_order;
  logic [15:0] inv_wb;
  deriv_t      expected_derivs[$];

  // rotate the gain-folded start vector to the phase, quadrant by quadrant
  task automatic rotate(input logic [31:0] phase, output longint c, output longint s);
    longint x, y, z, nx;
    x = longint'(CORDIC_X0);
    y = 0;
    z = longint'({2'b00, phase[29:0]});
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_PHASE[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_PHASE[i]);
      end
      x = nx;
    end
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                   inout logic hit);
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    return v;
  endfunction

  // derivative of one item under the current register settings
  task automatic derive(input logic [15:0] hd, input logic signed [15:0] v,
                        input logic signed [14:0] phi, input logic signed [15:0] a,
                        input logic signed [15:0] dphi, output deriv_t d);
    longint hc, hs, sc, ss, tanv, hr, sp;
    longint unsigned ay, ax;
    logic sat, dummy;
    sat = 1'b0;
    dummy = 1'b0;
    sp = longint'(v);
    rotate({hd, 16'h0}, hc, hs);
    d.x = 16'(clamp((sp * hc + (64'sd1 <<< 29)) >>> 30, -32768, 32767, dummy));
    d.y = 16'(clamp((sp * hs + (64'sd1 <<< 29)) >>> 30, -32768, 32767, dummy));
    rotate({phi[14], phi, 16'h0}, sc, ss);
    ay = (ss < 0) ? -ss : ss;
    ax = (sc < 0) ? -sc : sc;
    if (ax == 0 || (ay << 16) > 64'd2147483647 * ax) begin
      tanv = TAN_CLIP;
      sat = 1'b1;
    end else begin
      tanv = longint'((ay << 16) / ax);
    end
    if ((ss < 0) != (sc < 0)) tanv = -tanv;
    hr = (sp * tanv * longint'({48'h0, inv_wb}) + (64'sd1 <<< 15)) >>> 16;
    d.hr  = 32'(clamp(hr, -64'sd2147483648, 64'sd2147483647, sat));
    d.sr  = second_order ? a : 16'sd0;
    d.st  = second_order ? dphi : 16'sd0;
    d.sat = sat;
  endtask

  // channel values are stable at the falling edge; a handshake seen here
  // completes at the next rising edge
  always @(negedge clk) begin
    deriv_t d, e;
    if (rst) begin
      second_order = 1'b1;
      inv_wb = 16'd512;
      expected_derivs.delete();
      fails <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODEL_ORDER:   second_order = cfg_data[0];
          CFG_INV_WHEELBASE: inv_wb = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        derive(heading, speed, steer_angle, accel, steer_rate_in, d);
        expected_derivs.push_back(d);
      end
      if (out_valid && out_ready) begin
        if (expected_derivs.size() == 0) begin
          $error("result item with no item outstanding");
          fails <= fails + 1;
        end else begin
          e = expected_derivs.pop_front();
          if (x_rate !== e.x || y_rate !== e.y || heading_rate !== e.hr ||
              speed_rate !== e.sr || steer_rate_out !== e.st || saturated !== e.sat)
            fails <= fails + 1;
          if (x_rate !== e.x)
            $error("x_rate: expected %0d, got %0d", e.x, x_rate);
          if (y_rate !== e.y)
            $error("y_rate: expected %0d, got %0d", e.y, y_rate);
          if (heading_rate !== e.hr)
            $error("heading_rate: expected %0d, got %0d", e.hr, heading_rate);
          if (speed_rate !== e.sr)
            $error("speed_rate: expected %0d, got %0d", e.sr, speed_rate);
          if (steer_rate_out !== e.st)
            $error("steer_rate_out: expected %0d, got %0d", e.st, steer_rate_out);
          if (saturated !== e.sat)
            $error("saturated: expected %0b, got %0b", e.sat, saturated);
        end
      end
    end
    pending <= expected_derivs.size();
  end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Stimulus for the bicycle model derivative block: directed corner items,
// then random items under several register settings, with bursty input,
// a stalling output side and one long output hold-off.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  import bmsd_pkg::*;

  localparam int LATENCY     = 67;
  localparam int IDLE_LIMIT  = 5000;
  localparam int PHASE_ITEMS = 230;
  localparam logic [1:0] UNMAPPED_INDEX = 2'd3;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        heading;
  logic signed [15:0] speed;
  logic signed [14:0] steer_angle;
  logic signed [15:0] accel;
  logic signed [15:0] steer_rate_in;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] x_rate;
  logic signed [15:0] y_rate;
  logic signed [31:0] heading_rate;
  logic signed [15:0] speed_rate;
  logic signed [15:0] steer_rate_out;
  logic               saturated;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 fails;
  int                 pending;
  int                 idle_cycles;
  logic               long_hold;

  bicycle_model_state_derivative uut (.*);

  bmsd_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no handshake on any channel for too long ends the run
  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: ready stretches, random stalls, and one long hold-off on request
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        for (int i = 0; i < 400; i++) @(posedge clk);
        long_hold = 1'b0;
      end
      n = $urandom_range(1, 40);
      case ($urandom_range(0, 2))
        0: for (int i = 0; i < n; i++) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end
        1: for (int i = 0; i < n; i++) begin
          out_ready <= ($urandom_range(0, 3) != 0);
          @(posedge clk);
        end
        default: for (int i = 0; i < n; i++) begin
          out_ready <= ($urandom_range(0, 2) == 0);
          @(posedge clk);
        end
      endcase
    end
  end

  // offer one item and return at the edge where it is taken
  task automatic send_item(input logic [15:0] h, input logic signed [15:0] v,
                           input logic signed [14:0] phi, input logic signed [15:0] a,
                           input logic signed [15:0] dphi);
    logic taken;
    in_valid <= 1'b1;
    heading <= h;
    speed <= v;
    steer_angle <= phi;
    accel <= a;
    steer_rate_in <= dphi;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // let every outstanding item drain before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // random 16-bit value leaning toward the ends of the range
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 15)) ^ {16{$urandom_range(0, 1) == 1}};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] pick_steer();
    case ($urandom_range(0, 7))
      0: return 15'h3FFF - 15'($urandom_range(0, 8));
      1: return 15'h4000 + 15'($urandom_range(0, 8));
      2: return 15'($urandom_range(0, 3)) ^ {15{$urandom_range(0, 1) == 1}};
      default: return 15'($urandom);
    endcase
  endfunction

  // bursts of items with random gaps between them
  task automatic random_items(input int count);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_item(pick16(), pick16(), pick_steer(), pick16(), pick16());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [15:0] hd[5];
    in_valid <= 1'b0;
    heading <= '0;
    speed <= '0;
    steer_angle <= '0;
    accel <= '0;
    steer_rate_in <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MODEL_ORDER;
    cfg_data <= '0;
    long_hold = 1'b0;
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, heading quadrants, speed and steering extremes
    hd = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
    foreach (hd[i]) send_item(hd[i], 16'sh7FFF, 15'sd0, 16'sh7FFF, 16'sh8000);
    send_item(16'h2000, -16'sd32768, 15'sd16383, 16'sh8000, 16'sh7FFF);
    send_item(16'h6000, 16'sh7FFF, -15'sd16384, 16'sd0, 16'sd0);
    send_item(16'h1234, 16'sd0, 15'sd16383, 16'sd1, -16'sd1);
    send_item(16'hA000, 16'sh7FFF, 15'sd8192, 16'sd0, 16'sd0);
    send_item(16'hE000, -16'sd32768, -15'sd8191, 16'sd0, 16'sd0);
    drain();
    // first-order mode, wheelbase 0.2, and a write to an unmapped index
    write_reg(CFG_MODEL_ORDER, 16'd0);
    write_reg(CFG_INV_WHEELBASE, 16'd1280);
    write_reg(UNMAPPED_INDEX, 16'hFFFF);
    send_item(16'h1000, 16'sh7FFF, 15'sd16000, 16'sh7FFF, 16'sh8000);
    send_item(16'h9000, -16'sd32768, -15'sd16000, 16'sh8000, 16'sh7FFF);
    drain();
    // largest and zero inverse wheelbase
    write_reg(CFG_INV_WHEELBASE, 16'hFFFF);
    send_item(16'h3000, 16'sh7FFF, 15'sd12000, 16'sd5, 16'sd6);
    send_item(16'h3000, 16'sd1, 15'sd1, 16'sd5, 16'sd6);
    drain();
    write_reg(CFG_INV_WHEELBASE, 16'd0);
    send_item(16'h7000, 16'sh7FFF, 15'sd16383, 16'sd5, 16'sd6);
    drain();

    // random phases under different settings; the first carries the long hold
    write_reg(CFG_MODEL_ORDER, 16'd1);
    write_reg(CFG_INV_WHEELBASE, 16'd512);
    long_hold = 1'b1;
    random_items(PHASE_ITEMS);
    drain();
    write_reg(CFG_MODEL_ORDER, 16'd0);
    write_reg(CFG_INV_WHEELBASE, 16'd1280);
    random_items(PHASE_ITEMS);
    drain();
    write_reg(CFG_INV_WHEELBASE, 16'hFFFF);
    random_items(PHASE_ITEMS);
    drain();
    write_reg(CFG_MODEL_ORDER, 16'd1);
    write_reg(CFG_INV_WHEELBASE, 16'd1);
    random_items(PHASE_ITEMS);
    drain();
    write_reg(CFG_INV_WHEELBASE, 16'($urandom_range(1, 65535)));
    random_items(PHASE_ITEMS);
    drain();

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/bmsd_pkg.sv
rtl/bmsd_cordic.sv
rtl/bicycle_model_state_derivative.sv
tb/sv/bmsd_checker.sv
tb/sv/tb.sv
